// File: design/fla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants for the free-list chunk allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int unsigned MAX_CHUNKS = 1024;
    localparam int unsigned IDX_W      = $clog2(MAX_CHUNKS);
    localparam int unsigned CNT_W      = IDX_W + 1;
    localparam int unsigned LINK_W     = IDX_W + 1;
    localparam int unsigned SIZE_W     = 17;
    localparam int unsigned OFS_W      = 26;
    localparam int unsigned PROD_W     = IDX_W + SIZE_W;

    localparam logic [SIZE_W-1:0] CHUNK_BYTES_RESET = SIZE_W'(64);

    // Request kinds.
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_EXPAND = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] chunk_index;
        logic [CNT_W-1:0] expand_count;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted_index;
        logic [OFS_W-1:0] granted_offset;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ALLOC_WAIT,
        S_EXPAND,
        S_RESP
    } state_t;

    typedef struct packed {
        logic       load;
        logic       alloc_rd;
        logic       pop;
        logic       free_push;
        logic       exp_start;
        logic       exp_step;
        logic       res_set;
        logic [1:0] res_code;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       head_live;
        logic       free_ok;
        logic       expand_ok;
        logic       exp_last;
        logic       out_free;
    } sts_t;

endpackage

// File: design/fla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_ctrl
// Sequencer for the chunk allocator: decodes a request and steps the datapath.
// ----------------------------------------------------------------------------
module fla_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  fla_pkg::sts_t sts,
    output fla_pkg::cmd_t cmd
);

    fla_pkg::state_t state_reg;
    fla_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fla_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != fla_pkg::S_IDLE);
        case (state_reg)
            fla_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = fla_pkg::S_EXEC;
                end
            end
            fla_pkg::S_EXEC:
            begin
                state_next = fla_pkg::S_RESP;
                case (sts.action)
                    fla_pkg::ACT_ALLOC:
                    begin
                        if (sts.head_live)
                        begin
                            cmd.alloc_rd = 1'b1;
                            state_next   = fla_pkg::S_ALLOC_WAIT;
                        end
                        else
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = fla_pkg::STAT_EMPTY;
                        end
                    end
                    fla_pkg::ACT_FREE:
                    begin
                        cmd.res_set = 1'b1;
                        if (sts.free_ok)
                        begin
                            cmd.free_push = 1'b1;
                            cmd.res_code  = fla_pkg::STAT_OK;
                        end
                        else
                        begin
                            cmd.res_code = fla_pkg::STAT_REJECT;
                        end
                    end
                    fla_pkg::ACT_EXPAND:
                    begin
                        if (sts.expand_ok)
                        begin
                            cmd.exp_start = 1'b1;
                            state_next    = fla_pkg::S_EXPAND;
                        end
                        else
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = fla_pkg::STAT_REJECT;
                        end
                    end
                    default:
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = fla_pkg::STAT_REJECT;
                    end
                endcase
            end
            fla_pkg::S_ALLOC_WAIT:
            begin
                cmd.pop    = 1'b1;
                state_next = fla_pkg::S_RESP;
            end
            fla_pkg::S_EXPAND:
            begin
                cmd.exp_step = 1'b1;
                if (sts.exp_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = fla_pkg::STAT_OK;
                    state_next   = fla_pkg::S_RESP;
                end
            end
            fla_pkg::S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fla_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: design/fla_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_dp
// Datapath of the chunk allocator: link memory, list head, watermark,
// offset multiplier and the result register.
// ----------------------------------------------------------------------------
module fla_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fla_pkg::req_t                 in_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [fla_pkg::SIZE_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output fla_pkg::rsp_t                 out_data,
    input  fla_pkg::cmd_t                 cmd,
    output fla_pkg::sts_t                 sts
);

    logic [fla_pkg::LINK_W-1:0] link_mem [fla_pkg::MAX_CHUNKS];

    fla_pkg::req_t               item_reg;
    logic [fla_pkg::SIZE_W-1:0]  chunk_bytes_reg;
    logic                        head_live_reg;
    logic [fla_pkg::IDX_W-1:0]   head_reg;
    logic [fla_pkg::CNT_W-1:0]   watermark_reg;
    logic [fla_pkg::IDX_W-1:0]   k_reg;
    logic [fla_pkg::IDX_W-1:0]   top_reg;
    logic [fla_pkg::LINK_W-1:0]  rd_data_reg;
    logic [fla_pkg::OFS_W-1:0]   prod_reg;
    fla_pkg::rsp_t               res_reg;
    fla_pkg::rsp_t               out_reg;
    logic                        out_valid_reg;

    logic [fla_pkg::PROD_W-1:0]  prod_full;
    logic [fla_pkg::CNT_W:0]     exp_sum;
    logic                        exp_last;
    logic                        mem_we;
    logic [fla_pkg::IDX_W-1:0]   mem_waddr;
    logic [fla_pkg::LINK_W-1:0]  mem_wdata;

    assign prod_full = fla_pkg::PROD_W'(head_reg) * fla_pkg::PROD_W'(chunk_bytes_reg);
    assign exp_sum   = {1'b0, watermark_reg} + {1'b0, item_reg.expand_count};
    assign exp_last  = (k_reg == top_reg);

    assign sts.action    = item_reg.action;
    assign sts.head_live = head_live_reg;
    assign sts.free_ok   = ({1'b0, item_reg.chunk_index} < watermark_reg);
    assign sts.expand_ok = (item_reg.expand_count != '0)
                        && (exp_sum <= (fla_pkg::CNT_W + 1)'(fla_pkg::MAX_CHUNKS));
    assign sts.exp_last  = exp_last;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // A freed chunk and the last chunk of an expand link to the old head; the other expand chunks link upward.
    always_comb
    begin
        mem_we    = cmd.free_push || cmd.exp_step;
        mem_waddr = cmd.free_push ? item_reg.chunk_index : k_reg;
        if (cmd.free_push || exp_last)
        begin
            mem_wdata = {head_live_reg, head_reg};
        end
        else
        begin
            mem_wdata = {1'b1, k_reg + fla_pkg::IDX_W'(1)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.alloc_rd)
        begin
            rd_data_reg <= link_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_bytes_reg <= fla_pkg::CHUNK_BYTES_RESET;
            head_live_reg   <= 1'b0;
            watermark_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                chunk_bytes_reg <= cfg_data;
            end
            if (cmd.pop)
            begin
                head_live_reg <= rd_data_reg[fla_pkg::IDX_W];
            end
            else if (cmd.free_push || (cmd.exp_step && exp_last))
            begin
                head_live_reg <= 1'b1;
            end
            if (cmd.exp_step && exp_last)
            begin
                watermark_reg <= {1'b0, top_reg} + fla_pkg::CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.alloc_rd)
        begin
            prod_reg <= prod_full[fla_pkg::OFS_W-1:0];
        end
        if (cmd.pop)
        begin
            head_reg <= rd_data_reg[fla_pkg::IDX_W-1:0];
        end
        else if (cmd.free_push)
        begin
            head_reg <= item_reg.chunk_index;
        end
        else if (cmd.exp_step && exp_last)
        begin
            head_reg <= watermark_reg[fla_pkg::IDX_W-1:0];
        end
        if (cmd.exp_start)
        begin
            k_reg   <= watermark_reg[fla_pkg::IDX_W-1:0];
            top_reg <= fla_pkg::IDX_W'(exp_sum - (fla_pkg::CNT_W + 1)'(1));
        end
        else if (cmd.exp_step)
        begin
            k_reg <= k_reg + fla_pkg::IDX_W'(1);
        end
        if (cmd.pop)
        begin
            res_reg.status         <= fla_pkg::STAT_OK;
            res_reg.granted_index  <= head_reg;
            res_reg.granted_offset <= prod_reg;
        end
        else if (cmd.res_set)
        begin
            res_reg.status         <= cmd.res_code;
            res_reg.granted_index  <= '0;
            res_reg.granted_offset <= '0;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while held");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_rd |-> head_live_reg)
        else $error("link read issued on an empty list");

    a_watermark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        watermark_reg <= fla_pkg::CNT_W'(fla_pkg::MAX_CHUNKS))
        else $error("watermark beyond capacity");

    a_nongrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != fla_pkg::STAT_OK)
        |-> (out_reg.granted_index == '0 && out_reg.granted_offset == '0))
        else $error("failed request carries a nonzero grant");

    a_expand_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exp_step && exp_last) |=> (watermark_reg > $past(watermark_reg)))
        else $error("expand did not advance the watermark");

endmodule

// File: design/free_list_chunk_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_chunk_allocator
// Fixed-size chunk pool with a LIFO free list kept as links in a link memory.
// ----------------------------------------------------------------------------
// One request is handled at a time; the input is stalled from acceptance until
// the result is loaded into the output register, which then holds it for the
// consumer while the next request is already taken. A free, an empty alloc or
// any rejected request goes from decode straight to the response state, a
// successful alloc passes an extra wait state (one registered read of the
// single-read-port link memory plus a registered index-times-size multiply),
// and a successful expand steps once per new chunk, since the link memory's
// one write port links one new chunk per cycle. Extra cycles are added only
// while a finished result waits in the output register. The chunk size
// register may be written at any time the block is idle and is always ready.
module free_list_chunk_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  fla_pkg::req_t              in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output fla_pkg::rsp_t              out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fla_pkg::SIZE_W-1:0] cfg_data
);

    fla_pkg::cmd_t cmd;
    fla_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    fla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fla_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the free-list chunk allocator. Alloc, free and
// expand requests, both crafted and random, are sent while both sides idle
// and stall at random. A shadow of the free list, the watermark and the chunk
// size predicts every response, which is then checked field by field.
// ----------------------------------------------------------------------------
module tb;
    import fla_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int unsigned HOLD_CYCLES = 80;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    req_t              in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    rsp_t              out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;

    free_list_chunk_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the pool: each link holds {live, next index}.
    logic [LINK_W-1:0] link_shadow [MAX_CHUNKS];
    logic [IDX_W-1:0]  head_idx = '0;
    logic              head_live = 1'b0;
    int unsigned       watermark_q = 0;
    logic [SIZE_W-1:0] chunk_size = CHUNK_BYTES_RESET;

    req_t             req_pending  [$];
    rsp_t             rsp_expected [$];
    logic [IDX_W-1:0] chunks_out   [$];

    int err_cnt = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int in_gap = 0;
    int stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rsp_t pool_step(req_t r);
        rsp_t                   res;
        int unsigned            top;
        logic [IDX_W-1:0]       got;
        logic [PROD_W-1:0]      prod;
        res = '0;
        res.status = STAT_REJECT;
        case (r.action)
            ACT_ALLOC:
            begin
                if (!head_live)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    got = head_idx;
                    head_live = link_shadow[got][IDX_W];
                    head_idx = link_shadow[got][IDX_W-1:0];
                    prod = got * chunk_size;
                    res.status = STAT_OK;
                    res.granted_index = got;
                    res.granted_offset = prod[OFS_W-1:0];
                end
            end
            ACT_FREE:
            begin
                if (r.chunk_index < watermark_q)
                begin
                    link_shadow[r.chunk_index] = {head_live, head_idx};
                    head_idx = r.chunk_index;
                    head_live = 1'b1;
                    res.status = STAT_OK;
                end
            end
            ACT_EXPAND:
            begin
                if (r.expand_count != 0 && watermark_q + r.expand_count <= MAX_CHUNKS)
                begin
                    top = watermark_q + r.expand_count - 1;
                    for (int unsigned k = watermark_q; k < top; k++)
                        link_shadow[k] = {1'b1, IDX_W'(k + 1)};
                    link_shadow[top] = {head_live, head_idx};
                    head_idx = IDX_W'(watermark_q);
                    head_live = 1'b1;
                    watermark_q = watermark_q + r.expand_count;
                    res.status = STAT_OK;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Request driver: predicts each request as it is accepted.
    always @(posedge clk)
    begin : drive_req
        rsp_t rsp;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                rsp = pool_step(in_data);
                rsp_expected.push_back(rsp);
                if (in_data.action == ACT_ALLOC && rsp.status == STAT_OK)
                    chunks_out.push_back(rsp.granted_index);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_pending.size() > 0 && idle_on && $urandom_range(0, 9) == 0)
                begin
                    in_gap = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else if (req_pending.size() > 0)
                begin
                    in_data <= req_pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response stall: random bursts, plus one long hold on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rsp_expected.size() == 0)
            begin
                $display("%0t: unexpected response, status %0d index %0d offset %0d",
                         $time, out_data.status, out_data.granted_index,
                         out_data.granted_offset);
                err_cnt++;
            end
            else
            begin
                want = rsp_expected.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("granted_index", want.granted_index, out_data.granted_index);
                check_field("granted_offset", want.granted_offset, out_data.granted_offset);
            end
        end
    end

    task automatic push_req(logic [1:0] act, int unsigned idx, int unsigned cnt);
        req_t r;
        r.action = act;
        r.chunk_index = IDX_W'(idx);
        r.expand_count = CNT_W'(cnt);
        req_pending.push_back(r);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_pending.size() != 0 || in_valid || rsp_expected.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        chunk_size = value;
    endtask

    // Mostly well-formed traffic: frees return chunks that were handed out,
    // expands add a few chunks. The rest is stray frees, odd counts and
    // unknown actions.
    task automatic random_phase(int n, int alloc_pct);
        req_t r;
        int   sel;
        int   pick;
        int   k;
        for (int i = 0; i < n; i++)
        begin
            while (req_pending.size() > 2)
                @(negedge clk);
            r.action = ACT_ALLOC;
            r.chunk_index = IDX_W'($urandom);
            r.expand_count = CNT_W'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < alloc_pct)
            begin
                r.action = ACT_ALLOC;
            end
            else if (sel < 75 + (alloc_pct - 40) / 2)
            begin
                r.action = ACT_FREE;
                pick = $urandom_range(0, 9);
                if (chunks_out.size() > 0 && pick < 8)
                begin
                    k = $urandom_range(0, chunks_out.size() - 1);
                    r.chunk_index = chunks_out[k];
                    chunks_out.delete(k);
                end
                else if (watermark_q > 0 && pick < 9)
                begin
                    r.chunk_index = IDX_W'($urandom_range(0, watermark_q - 1));
                end
            end
            else if (sel < 96)
            begin
                r.action = ACT_EXPAND;
                if ($urandom_range(0, 9) < 8)
                    r.expand_count = CNT_W'($urandom_range(1, 4));
            end
            else
            begin
                r.action = ACT_UNKNOWN;
            end
            req_pending.push_back(r);
        end
    endtask

    initial
    begin
        for (int i = 0; i < MAX_CHUNKS; i++)
            link_shadow[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pool: nothing to hand out, nothing valid to free.
        push_req(ACT_ALLOC, 0, 0);
        push_req(ACT_FREE, 0, 0);
        push_req(ACT_EXPAND, 0, 0);
        push_req(ACT_EXPAND, 0, 2047);
        push_req(ACT_EXPAND, 0, MAX_CHUNKS + 1);
        push_req(ACT_UNKNOWN, 1023, 2047);
        // Pool creation, then a second expand in front of the first chunk.
        push_req(ACT_EXPAND, 0, 1);
        push_req(ACT_EXPAND, 0, 3);
        repeat (5) push_req(ACT_ALLOC, 0, 0);
        // Double free goes through: the chunk links to itself and keeps coming out.
        push_req(ACT_FREE, 2, 0);
        push_req(ACT_FREE, 2, 0);
        repeat (3) push_req(ACT_ALLOC, 0, 0);
        push_req(ACT_FREE, 1023, 0);
        push_req(ACT_FREE, 4, 0);
        push_req(ACT_FREE, 3, 0);
        push_req(ACT_ALLOC, 0, 0);
        wait_idle();

        write_size(SIZE_W'(8));
        random_phase(200, 40);
        wait_idle();

        // Odd size; the response side holds off long enough to back up the input.
        write_size(SIZE_W'(131071));
        random_phase(60, 40);
        @(negedge clk);
        hold_req = 1'b1;
        random_phase(140, 40);
        wait_idle();

        write_size(SIZE_W'(0));
        random_phase(200, 60);
        wait_idle();

        write_size(SIZE_W'($urandom_range(8, 65536)));
        random_phase(200, 40);
        wait_idle();

        // Size 65536, pool filled to capacity, no idling from here on.
        write_size(SIZE_W'(65536));
        idle_on = 1'b0;
        // Let a stall burst that is still running finish first.
        wait (stall_left == 0);
        @(posedge clk);
        if (watermark_q < MAX_CHUNKS)
            push_req(ACT_EXPAND, 0, MAX_CHUNKS - watermark_q);
        push_req(ACT_EXPAND, 0, 1);
        push_req(ACT_FREE, MAX_CHUNKS - 1, 0);
        push_req(ACT_ALLOC, 0, 0);
        random_phase(180, 45);
        wait_idle();

        if (err_cnt == 0 && rsp_expected.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
